FILE: design/calu_pkg.sv
package calu_pkg;

	typedef enum logic [4:0] {
		ACT_ADD   = 5'd0,
		ACT_ADC   = 5'd1,
		ACT_SUB   = 5'd2,
		ACT_SBC   = 5'd3,
		ACT_AND   = 5'd4,
		ACT_XOR   = 5'd5,
		ACT_OR    = 5'd6,
		ACT_CP    = 5'd7,
		ACT_INC   = 5'd8,
		ACT_DEC   = 5'd9,
		ACT_RLCA  = 5'd10,
		ACT_RRCA  = 5'd11,
		ACT_RLA   = 5'd12,
		ACT_RRA   = 5'd13,
		ACT_DAA   = 5'd14,
		ACT_CPL   = 5'd15,
		ACT_SCF   = 5'd16,
		ACT_CCF   = 5'd17,
		ACT_ADD16 = 5'd18
	} action_t;

	typedef struct packed {
		logic [4:0]  action;
		logic [15:0] operand_a;
		logic [15:0] operand_b;
		logic        zero_in;
		logic        sub_in;
		logic        half_in;
		logic        carry_in;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] value;
		logic        zero_out;
		logic        sub_out;
		logic        half_out;
		logic        carry_out;
	} alu_rsp_t;

	localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
	localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
	localparam logic [7:0] DAA_ADD_HI   = 8'h60;
	localparam logic [7:0] DAA_ADD_LO   = 8'h06;
	localparam logic [7:0] DAA_SUB_HI   = 8'hA0;
	localparam logic [7:0] DAA_SUB_LO   = 8'hFA;

endpackage

FILE: design/calu_if.sv
interface calu_req_if import calu_pkg::*; ();
	logic     valid;
	logic     ready;
	alu_req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface calu_rsp_if import calu_pkg::*; ();
	logic     valid;
	logic     ready;
	alu_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/cpu_alu_with_flags.sv
// Two-stage ALU: request register, then result register.
// An accepted request waits in the request register until its result can be registered.
// Throughput: one request per cycle; while a result waits at the output, the
// result register holds and the request register takes a request only if it is empty.
// Reset (arst_n, async, active low) clears the stage valid bits only.
module cpu_alu_with_flags import calu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	calu_req_if.sink   req,
	calu_rsp_if.source rsp
);

	logic     valid_s1;
	alu_req_t req_s1;
	logic     valid_s2;
	alu_rsp_t rsp_s2;
	logic     advance;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
	end

	// datapath
	logic [7:0]  a, b;
	logic        cin;
	logic [8:0]  add9, sub9;
	logic [4:0]  hadd, hsub;
	logic [7:0]  inc8, dec8;
	logic        daa_hi, daa_lo;
	logic [7:0]  daa_r;
	logic [16:0] add17;
	logic [12:0] hadd16;
	logic [15:0] r;
	logic        z, n, h, c, setz;

	always_comb begin
		a      = req_s1.operand_a[7:0];
		b      = req_s1.operand_b[7:0];
		cin    = req_s1.carry_in && (req_s1.action == ACT_ADC || req_s1.action == ACT_SBC);
		add9   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
		hadd   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
		sub9   = {1'b0, a} - {1'b0, b} - {8'd0, cin};
		hsub   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};
		inc8   = a + 8'd1;
		dec8   = a - 8'd1;
		daa_hi = req_s1.carry_in || (a > DAA_HI_LIMIT);
		daa_lo = req_s1.half_in || (a[3:0] > DAA_LO_LIMIT);
		if (!req_s1.sub_in) begin
			daa_r = a + (daa_hi ? DAA_ADD_HI : 8'd0) + (daa_lo ? DAA_ADD_LO : 8'd0);
		end else begin
			daa_r = a + (req_s1.carry_in ? DAA_SUB_HI : 8'd0)
				+ (req_s1.half_in ? DAA_SUB_LO : 8'd0);
		end
		add17  = {1'b0, req_s1.operand_a} + {1'b0, req_s1.operand_b};
		hadd16 = {1'b0, req_s1.operand_a[11:0]} + {1'b0, req_s1.operand_b[11:0]};

		r    = 16'd0;
		z    = req_s1.zero_in;
		n    = req_s1.sub_in;
		h    = req_s1.half_in;
		c    = req_s1.carry_in;
		setz = 1'b1;

		case (req_s1.action)
			ACT_ADD, ACT_ADC: begin
				r = {8'd0, add9[7:0]};
				n = 1'b0;
				h = hadd[4];
				c = add9[8];
			end
			ACT_SUB, ACT_SBC: begin
				r = {8'd0, sub9[7:0]};
				n = 1'b1;
				h = hsub[4];
				c = sub9[8];
			end
			ACT_CP: begin
				r    = {8'd0, a};
				z    = (sub9[7:0] == 8'd0);
				setz = 1'b0;
				n    = 1'b1;
				h    = hsub[4];
				c    = sub9[8];
			end
			ACT_AND: begin
				r = {8'd0, a & b};
				n = 1'b0;
				h = 1'b1;
				c = 1'b0;
			end
			ACT_XOR: begin
				r = {8'd0, a ^ b};
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			ACT_OR: begin
				r = {8'd0, a | b};
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			ACT_INC: begin
				r = {8'd0, inc8};
				n = 1'b0;
				h = (inc8[3:0] == 4'h0);
			end
			ACT_DEC: begin
				r = {8'd0, dec8};
				n = 1'b1;
				h = (dec8[3:0] == 4'hF);
			end
			ACT_RLCA: begin
				r    = {8'd0, a[6:0], a[7]};
				c    = a[7];
				z    = 1'b0;
				n    = 1'b0;
				h    = 1'b0;
				setz = 1'b0;
			end
			ACT_RRCA: begin
				r    = {8'd0, a[0], a[7:1]};
				c    = a[0];
				z    = 1'b0;
				n    = 1'b0;
				h    = 1'b0;
				setz = 1'b0;
			end
			ACT_RLA: begin
				r    = {8'd0, a[6:0], req_s1.carry_in};
				c    = a[7];
				z    = 1'b0;
				n    = 1'b0;
				h    = 1'b0;
				setz = 1'b0;
			end
			ACT_RRA: begin
				r    = {8'd0, req_s1.carry_in, a[7:1]};
				c    = a[0];
				z    = 1'b0;
				n    = 1'b0;
				h    = 1'b0;
				setz = 1'b0;
			end
			ACT_DAA: begin
				r = {8'd0, daa_r};
				h = 1'b0;
				if (!req_s1.sub_in) begin
					c = daa_hi;
				end
			end
			ACT_CPL: begin
				r    = {8'd0, ~a};
				n    = 1'b1;
				h    = 1'b1;
				setz = 1'b0;
			end
			ACT_SCF: begin
				r    = {8'd0, a};
				n    = 1'b0;
				h    = 1'b0;
				c    = 1'b1;
				setz = 1'b0;
			end
			ACT_CCF: begin
				r    = {8'd0, a};
				n    = 1'b0;
				h    = 1'b0;
				c    = !req_s1.carry_in;
				setz = 1'b0;
			end
			ACT_ADD16: begin
				r    = add17[15:0];
				n    = 1'b0;
				h    = hadd16[12];
				c    = add17[16];
				setz = 1'b0;
			end
			default: begin
				r    = 16'd0;
				setz = 1'b0;
			end
		endcase

		if (setz) begin
			z = (r == 16'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2.value     <= r;
			rsp_s2.zero_out  <= z;
			rsp_s2.sub_out   <= n;
			rsp_s2.half_out  <= h;
			rsp_s2.carry_out <= c;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = rsp_s2;

endmodule
